### rtl/core/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

   // default geometry
   localparam int DEF_COLS = 80;
   localparam int DEF_ROWS = 25;

   // request codes
   localparam logic [1:0] REQ_PUT   = 2'd0;
   localparam logic [1:0] REQ_CLEAR = 2'd1;
   localparam logic [1:0] REQ_MOVE  = 2'd2;
   localparam logic [1:0] REQ_READ  = 2'd3;

   // characters
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [7:0] SPACE_CHAR   = 8'h20;

   // register file
   localparam int         CSR_IDX_W     = 2;
   localparam int         CSR_DATA_W    = 4;
   localparam logic [1:0] CSR_FILL_FORE = 2'd0;
   localparam logic [1:0] CSR_FILL_BACK = 2'd1;
   localparam logic [3:0] FILL_FORE_RST = 4'd7;
   localparam logic [3:0] FILL_BACK_RST = 4'd0;

   // field widths
   localparam int CELL_W = 16;
   localparam int POS_W  = 11;

endpackage

`default_nettype wire

### rtl/core/tcw_cell_mem.sv
`default_nettype none

module tcw_cell_mem #(
   parameter int DEPTH  = tcw_pkg::DEF_COLS * tcw_pkg::DEF_ROWS,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [ADDR_W-1:0]         wr_addr,
   input  wire logic [tcw_pkg::CELL_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [ADDR_W-1:0]         rd_addr,
   output logic      [tcw_pkg::CELL_W-1:0] rd_data
);

   logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/core/text_console_writer.sv
// response path: put character and move load the output register at once, or wait in
//   finish while it stalls; read cell goes via read and finish, clear via fill and
//   finish, a scrolling put via copy, drain, fill and finish, one store word per cycle
// throughput: one item at a time; one put or move per cycle unless stalled or scrolling
// reset: synchronous, active high; afterwards a clearing pass writes zero to all
//   ROWS*COLS cells, one per cycle, with req_stall high; csr writes are taken throughout
`default_nettype none

module text_console_writer #(
   parameter int COLS = tcw_pkg::DEF_COLS,
   parameter int ROWS = tcw_pkg::DEF_ROWS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_type,
   input  wire logic [7:0]                    req_ch,
   input  wire logic [3:0]                    req_fore,
   input  wire logic [3:0]                    req_back,
   input  wire logic [6:0]                    req_new_col,
   input  wire logic [4:0]                    req_new_row,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [tcw_pkg::POS_W-1:0]          rsp_cursor_pos,
   output logic [tcw_pkg::CELL_W-1:0]         rsp_cell_word,
   output logic                               rsp_move_ignored,
   // configuration
   input  wire logic                          csr_we,
   input  wire logic [tcw_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tcw_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH  = ROWS * COLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int COL_W  = $clog2(COLS);
   localparam int ROW_W  = $clog2(ROWS);
   // row times column product of the request fields, wide enough for 31*128+127
   localparam int LIN_W  = 12;

   localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);
   localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'((ROWS - 1) * COLS - 1);
   localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'((ROWS - 1) * COLS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_DRAIN,
      ST_FILL,
      ST_FINISH
   } state_type;

   // control state
   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    cnt_ff, cnt_in;
   logic                 sweep_init_ff, sweep_init_in;
   logic                 copy_v_ff, copy_v_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [ADDR_W-1:0]    base_ff, base_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [3:0]           fill_fore_ff, fill_fore_in;
   logic [3:0]           fill_back_ff, fill_back_in;

   // payload
   logic [ADDR_W-1:0]          copy_addr_ff, copy_addr_in;
   logic                       rd_ok_ff, rd_ok_in;
   logic [tcw_pkg::CELL_W-1:0] pend_word_ff, pend_word_in;
   logic                       pend_ign_ff, pend_ign_in;
   logic [tcw_pkg::POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [tcw_pkg::CELL_W-1:0] rsp_word_ff, rsp_word_in;
   logic                       rsp_ign_ff, rsp_ign_in;

   // store port
   logic                       mem_we;
   logic [ADDR_W-1:0]          mem_wa;
   logic [tcw_pkg::CELL_W-1:0] mem_wd;
   logic                       mem_re;
   logic [ADDR_W-1:0]          mem_ra;
   logic [tcw_pkg::CELL_W-1:0] mem_rd_data;

   logic                       out_free;
   logic                       rsp_load;
   logic                       wrap;
   logic                       in_range;
   logic [LIN_W-1:0]           row_prod;
   logic [LIN_W-1:0]           req_lin;
   logic [tcw_pkg::CELL_W-1:0] blank_word;

   tcw_cell_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_cell_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (mem_ra),
      .rd_data (mem_rd_data)
   );

   // request coordinate to linear address, shared by move and read
   assign row_prod = LIN_W'(req_new_row) * LIN_W'(COLS);
   assign req_lin  = row_prod + LIN_W'(req_new_col);
   assign in_range = ({1'b0, req_new_col} < 8'(COLS)) && ({1'b0, req_new_row} < 6'(ROWS));

   assign blank_word = {fill_back_ff, fill_fore_ff, tcw_pkg::SPACE_CHAR};

   // output register free when empty or drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      sweep_init_in = sweep_init_ff;
      copy_v_in     = (state_ff == ST_COPY);
      copy_addr_in  = cnt_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      base_in       = base_ff;
      rd_ok_in      = rd_ok_ff;
      pend_word_in  = pend_word_ff;
      pend_ign_in   = pend_ign_ff;
      fill_fore_in  = fill_fore_ff;
      fill_back_in  = fill_back_ff;
      rsp_load      = 1'b0;
      wrap          = 1'b0;
      mem_re        = 1'b0;
      mem_ra        = '0;
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd        = '0;

      // delayed write half of the scroll copy
      if (copy_v_ff) begin
         mem_we = 1'b1;
         mem_wa = copy_addr_ff;
         mem_wd = mem_rd_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pend_word_in = '0;
               pend_ign_in  = 1'b0;
               unique case (req_type)
                  tcw_pkg::REQ_PUT: begin
                     if (req_ch == tcw_pkg::NEWLINE_CHAR) begin
                        col_in = '0;
                        wrap   = 1'b1;
                     end else begin
                        mem_we = 1'b1;
                        mem_wa = ADDR_W'(base_ff + ADDR_W'(col_ff));
                        mem_wd = {req_back, req_fore, req_ch};
                        if (col_ff == LAST_COL) begin
                           col_in = '0;
                           wrap   = 1'b1;
                        end else begin
                           col_in = col_ff + 1'b1;
                        end
                     end
                     if (wrap) begin
                        if (row_ff == LAST_ROW) begin
                           // cursor stays on the bottom row, store scrolls
                           state_in = ST_COPY;
                           cnt_in   = '0;
                        end else begin
                           row_in  = row_ff + 1'b1;
                           base_in = ADDR_W'(base_ff + ADDR_W'(COLS));
                        end
                     end
                  end
                  tcw_pkg::REQ_CLEAR: begin
                     col_in        = '0;
                     row_in        = '0;
                     base_in       = '0;
                     cnt_in        = '0;
                     sweep_init_in = 1'b0;
                     state_in      = ST_FILL;
                  end
                  tcw_pkg::REQ_MOVE: begin
                     if (in_range) begin
                        col_in  = COL_W'(req_new_col);
                        row_in  = ROW_W'(req_new_row);
                        base_in = ADDR_W'(row_prod);
                     end else begin
                        pend_ign_in = 1'b1;
                     end
                  end
                  tcw_pkg::REQ_READ: begin
                     mem_re   = in_range;
                     mem_ra   = ADDR_W'(req_lin);
                     rd_ok_in = in_range;
                     state_in = ST_READ;
                  end
                  default: begin
                  end
               endcase
               // requests finished in idle go straight to the output register, or to finish if stalled
               if (state_in == ST_IDLE) begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_READ: begin
            pend_word_in = rd_ok_ff ? mem_rd_data : '0;
            state_in     = ST_FINISH;
         end
         ST_COPY: begin
            // read one row ahead, written back next cycle
            mem_re = 1'b1;
            mem_ra = ADDR_W'(cnt_ff + ADDR_W'(COLS));
            if (cnt_ff == COPY_LAST) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            cnt_in        = BOTTOM_ROW;
            sweep_init_in = 1'b0;
            state_in      = ST_FILL;
         end
         ST_FILL: begin
            mem_we = 1'b1;
            mem_wa = cnt_ff;
            mem_wd = sweep_init_ff ? '0 : blank_word;
            if (cnt_ff == LAST_ADDR) begin
               sweep_init_in = 1'b0;
               state_in      = sweep_init_ff ? ST_IDLE : ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // configuration, unknown indexes ignored
      if (csr_we) begin
         case (csr_index)
            tcw_pkg::CSR_FILL_FORE: fill_fore_in = csr_wdata;
            tcw_pkg::CSR_FILL_BACK: fill_back_in = csr_wdata;
            default: begin
            end
         endcase
      end

      // output register
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_pos_in   = rsp_load ? tcw_pkg::POS_W'(base_in + ADDR_W'(col_in)) : rsp_pos_ff;
      rsp_word_in  = rsp_load ? pend_word_in : rsp_word_ff;
      rsp_ign_in   = rsp_load ? pend_ign_in : rsp_ign_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FILL;
         cnt_ff        <= '0;
         sweep_init_ff <= 1'b1;
         copy_v_ff     <= 1'b0;
         col_ff        <= '0;
         row_ff        <= '0;
         base_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         fill_fore_ff  <= tcw_pkg::FILL_FORE_RST;
         fill_back_ff  <= tcw_pkg::FILL_BACK_RST;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         sweep_init_ff <= sweep_init_in;
         copy_v_ff     <= copy_v_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         base_ff       <= base_in;
         rsp_valid_ff  <= rsp_valid_in;
         fill_fore_ff  <= fill_fore_in;
         fill_back_ff  <= fill_back_in;
      end
      copy_addr_ff <= copy_addr_in;
      rd_ok_ff     <= rd_ok_in;
      pend_word_ff <= pend_word_in;
      pend_ign_ff  <= pend_ign_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_ign_ff   <= rsp_ign_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cursor_pos   = rsp_pos_ff;
   assign rsp_cell_word    = rsp_word_ff;
   assign rsp_move_ignored = rsp_ign_ff;

endmodule

`default_nettype wire

### rtl/core/tcw_checker.sv
`default_nettype none

module tcw_checker #(
   parameter int COLS = tcw_pkg::DEF_COLS,
   parameter int ROWS = tcw_pkg::DEF_ROWS
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [tcw_pkg::POS_W-1:0]     rsp_cursor_pos,
   input wire logic [tcw_pkg::CELL_W-1:0]    rsp_cell_word,
   input wire logic                          rsp_move_ignored
);

   localparam int POS_LIMIT = ROWS * COLS;

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cursor_pos)
         && $stable(rsp_cell_word) && $stable(rsp_move_ignored))
      else $error("stalled response changed");

   // cursor always inside the screen
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (POS_LIMIT > 2048) || (int'(rsp_cursor_pos) < POS_LIMIT))
      else $error("cursor position outside the screen");

   // an ignored move never carries a cell word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_move_ignored |-> rsp_cell_word == '0)
      else $error("ignored move with cell data");

   // clearing pass after reset blocks requests
   assert property (@(posedge clock)
      $past(reset) && !reset |-> req_stall)
      else $error("request taken during clearing pass");

   // no response comes out of the clearing pass
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response right after reset");

endmodule

bind text_console_writer tcw_checker #(
   .COLS (COLS),
   .ROWS (ROWS)
) u_tcw_checker (.*);

`default_nettype wire

### tb/sv/tb_text_console_writer.sv
`timescale 1ns / 1ps

module tb_text_console_writer;

   localparam int COLS   = tcw_pkg::DEF_COLS;
   localparam int ROWS   = tcw_pkg::DEF_ROWS;
   localparam int NCELLS = COLS * ROWS;

   // register indexes that decode to nothing, written to show they are ignored
   localparam logic [1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [1:0] CSR_SPARE_3 = 2'd3;

   localparam int PHASES        = 5;
   localparam int ITEMS_A_PHASE = 160;
   localparam int HOLD_CYCLES   = 300;
   // a scroll or clear walks the whole store, so the longest quiet gap is about one such
   // walk plus a receiver hold; take that several times over
   localparam int STUCK_LIMIT   = 8 * NCELLS + 4 * HOLD_CYCLES;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] ch;
      logic [3:0] fore;
      logic [3:0] back;
      logic [6:0] col;
      logic [4:0] row;
   } console_req_type;

   typedef struct packed {
      logic [tcw_pkg::POS_W-1:0]  pos;
      logic [tcw_pkg::CELL_W-1:0] word;
      logic                       ignored;
   } console_rsp_type;

   // console predictor plus the queue of responses it still owes
   class console_scoreboard;
      bit [15:0]       cells [NCELLS];
      int unsigned     col;
      int unsigned     row;
      bit [3:0]        fill_fore;
      bit [3:0]        fill_back;
      console_rsp_type owed [$];
      int              errors;

      function new();
         foreach (cells[i]) cells[i] = '0;
         col       = 0;
         row       = 0;
         fill_fore = tcw_pkg::FILL_FORE_RST;
         fill_back = tcw_pkg::FILL_BACK_RST;
         errors    = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [3:0] val);
         if (idx == tcw_pkg::CSR_FILL_FORE) fill_fore = val;
         else if (idx == tcw_pkg::CSR_FILL_BACK) fill_back = val;
      endfunction

      function bit [15:0] blank_cell();
         return {fill_back, fill_fore, tcw_pkg::SPACE_CHAR};
      endfunction

      // cursor drops a row; off the bottom the store scrolls up by one row
      function void next_row();
         row++;
         if (row >= ROWS) begin
            for (int i = 0; i < (ROWS - 1) * COLS; i++) cells[i] = cells[i + COLS];
            for (int i = 0; i < COLS; i++) cells[(ROWS - 1) * COLS + i] = blank_cell();
            row = ROWS - 1;
         end
      endfunction

      function void note_request(console_req_type r);
         console_rsp_type want;
         want = '0;
         case (r.kind)
            tcw_pkg::REQ_PUT: begin
               if (r.ch == tcw_pkg::NEWLINE_CHAR) begin
                  col = 0;
                  next_row();
               end else begin
                  cells[row * COLS + col] = {r.back, r.fore, r.ch};
                  col++;
                  if (col >= COLS) begin
                     col = 0;
                     next_row();
                  end
               end
            end
            tcw_pkg::REQ_CLEAR: begin
               foreach (cells[i]) cells[i] = blank_cell();
               col = 0;
               row = 0;
            end
            tcw_pkg::REQ_MOVE: begin
               if (r.col >= COLS || r.row >= ROWS) begin
                  want.ignored = 1'b1;
               end else begin
                  col = 32'(r.col);
                  row = 32'(r.row);
               end
            end
            default: begin
               if (r.col < COLS && r.row < ROWS) want.word = cells[r.row * COLS + r.col];
            end
         endcase
         want.pos = tcw_pkg::POS_W'(row * COLS + col);
         owed.push_back(want);
      endfunction

      function void check_response(console_rsp_type got);
         console_rsp_type want;
         if (owed.size() == 0) begin
            errors++;
            $display("%0t: response with nothing owed: expected none, actual pos=%0d word=%h",
                     $time, got.pos, got.word);
            return;
         end
         want = owed.pop_front();
         if (got.pos !== want.pos) begin
            errors++;
            $display("%0t: cursor_pos expected %0d actual %0d", $time, want.pos, got.pos);
         end
         if (got.word !== want.word) begin
            errors++;
            $display("%0t: cell_word expected %h actual %h", $time, want.word, got.word);
         end
         if (got.ignored !== want.ignored) begin
            errors++;
            $display("%0t: move_ignored expected %0b actual %0b", $time, want.ignored,
                     got.ignored);
         end
      endfunction

      function int pending();
         return owed.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   // request side
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [1:0] req_type    = tcw_pkg::REQ_PUT;
   logic [7:0] req_ch      = '0;
   logic [3:0] req_fore    = '0;
   logic [3:0] req_back    = '0;
   logic [6:0] req_new_col = '0;
   logic [4:0] req_new_row = '0;

   // response side
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [tcw_pkg::POS_W-1:0]   rsp_cursor_pos;
   logic [tcw_pkg::CELL_W-1:0]  rsp_cell_word;
   logic                        rsp_move_ignored;

   // register port
   logic [0:0]                         csr_we    = 1'b0;
   logic [tcw_pkg::CSR_IDX_W-1:0]      csr_index = tcw_pkg::CSR_FILL_FORE;
   logic [tcw_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;

   console_scoreboard sb;

   // calm turns off idling on both sides; hold_off asks the receiver for a long stall
   bit calm     = 1'b0;
   bit hold_off = 1'b0;
   int stuck_cycles = 0;

   always #5 clock = ~clock;

   text_console_writer #(
      .COLS(COLS),
      .ROWS(ROWS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_ch           (req_ch),
      .req_fore         (req_fore),
      .req_back         (req_back),
      .req_new_col      (req_new_col),
      .req_new_row      (req_new_row),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cursor_pos   (rsp_cursor_pos),
      .rsp_cell_word    (rsp_cell_word),
      .rsp_move_ignored (rsp_move_ignored),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // monitor: note each request transfer first, then check each response transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request('{req_type, req_ch, req_fore, req_back, req_new_col, req_new_row});
         if (rsp_valid && !rsp_stall)
            sb.check_response('{rsp_cursor_pos, rsp_cell_word, rsp_move_ignored});
      end
   end

   // watchdog: counts cycles without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // receiver: random stalls, none while calm, and one long hold on request
   initial begin
      @(negedge clock);
      forever begin
         if (hold_off) begin
            hold_off = 1'b0;
            rsp_stall <= 1'b1;
            // count the hold here so the sender keeps offering and the block backs up
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < 38);
         @(negedge clock);
      end
   end

   function automatic console_req_type make_req(logic [1:0] kind, logic [7:0] ch,
                                                logic [3:0] fore, logic [3:0] back,
                                                logic [6:0] col, logic [4:0] row);
      console_req_type r;
      r = '{kind, ch, fore, back, col, row};
      return r;
   endfunction

   // random request, mostly text so the cursor runs into wraps and scrolls
   function automatic console_req_type random_request();
      console_req_type r;
      int unsigned     pick;
      int unsigned     sel;
      r.kind = tcw_pkg::REQ_PUT;
      r.ch   = 8'($urandom_range(0, 255));
      r.fore = 4'($urandom_range(0, 15));
      r.back = 4'($urandom_range(0, 15));
      r.col  = 7'($urandom_range(0, 127));
      r.row  = 5'($urandom_range(0, 31));
      pick   = $urandom_range(0, 99);
      sel    = $urandom_range(0, 99);
      if (pick < 2) begin
         r.kind = tcw_pkg::REQ_CLEAR;
      end else if (pick < 62) begin
         r.kind = tcw_pkg::REQ_PUT;
         if (sel < 6) r.ch = tcw_pkg::NEWLINE_CHAR;
      end else if (pick < 77) begin
         r.kind = tcw_pkg::REQ_MOVE;
         if (sel < 30) begin
            // near the bottom right corner, where wrap and scroll live
            r.col = 7'(COLS - 1 - $urandom_range(0, 3));
            r.row = 5'(ROWS - 1);
         end else if (sel < 85) begin
            r.col = 7'($urandom_range(0, COLS - 1));
            r.row = 5'($urandom_range(0, ROWS - 1));
         end
      end else begin
         r.kind = tcw_pkg::REQ_READ;
         if (sel < 50) begin
            // the cell just written, one step behind the cursor
            if (sb.col > 0) begin
               r.col = 7'(sb.col - 1);
               r.row = 5'(sb.row);
            end else begin
               r.col = (sb.row > 0) ? 7'(COLS - 1) : 7'd0;
               r.row = (sb.row > 0) ? 5'(sb.row - 1) : 5'd0;
            end
         end else if (sel < 85) begin
            r.col = 7'($urandom_range(0, COLS - 1));
            r.row = 5'($urandom_range(0, ROWS - 1));
         end
      end
      return r;
   endfunction

   // offer one request and return at the falling edge after its transfer
   task automatic send_req(input console_req_type r);
      while (!calm && $urandom_range(0, 99) < 38) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= r.kind;
      req_ch      <= r.ch;
      req_fore    <= r.fore;
      req_back    <= r.back;
      req_new_col <= r.col;
      req_new_row <= r.row;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // stop offering and wait until every owed response has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // write both fill colors, then poke the unused indexes with junk
   task automatic set_fill(input logic [3:0] fore, input logic [3:0] back);
      logic [1:0] idx  [4];
      logic [3:0] data [4];
      idx  = '{tcw_pkg::CSR_FILL_FORE, tcw_pkg::CSR_FILL_BACK, CSR_SPARE_2, CSR_SPARE_3};
      data = '{fore, back, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= data[i];
         sb.write_reg(idx[i], data[i]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // directed: byte extremes, colors, wrap and scroll at the corner, newline on the
   // last row, moves and reads just past the edge and at the field maximum, clear
   task automatic directed_requests();
      send_req(make_req(tcw_pkg::REQ_READ,  8'h00, 4'h0, 4'h0, 7'd0,   5'd0));
      send_req(make_req(tcw_pkg::REQ_PUT,   8'h41, 4'hF, 4'hF, 7'd127, 5'd31));
      send_req(make_req(tcw_pkg::REQ_PUT,   8'h00, 4'h0, 4'h0, 7'd0,   5'd0));
      send_req(make_req(tcw_pkg::REQ_PUT,   8'hFF, 4'hF, 4'h0, 7'd0,   5'd0));
      // top bit set: must not spill into the attribute byte
      send_req(make_req(tcw_pkg::REQ_PUT,   8'h80, 4'h0, 4'hF, 7'd0,   5'd0));
      send_req(make_req(tcw_pkg::REQ_READ,  8'hFF, 4'hF, 4'hF, 7'd3,   5'd0));
      send_req(make_req(tcw_pkg::REQ_READ,  8'h00, 4'h0, 4'h0, 7'd2,   5'd0));
      send_req(make_req(tcw_pkg::REQ_MOVE,  8'h00, 4'h0, 4'h0, 7'd127, 5'd31));
      send_req(make_req(tcw_pkg::REQ_MOVE,  8'h00, 4'h0, 4'h0, 7'(COLS), 5'd0));
      send_req(make_req(tcw_pkg::REQ_MOVE,  8'h00, 4'h0, 4'h0, 7'd0,   5'(ROWS)));
      send_req(make_req(tcw_pkg::REQ_MOVE,  8'h00, 4'h0, 4'h0, 7'(COLS - 1), 5'd0));
      send_req(make_req(tcw_pkg::REQ_PUT,   8'h5A, 4'h3, 4'hC, 7'd0,   5'd0));
      send_req(make_req(tcw_pkg::REQ_READ,  8'h00, 4'h0, 4'h0, 7'(COLS - 1), 5'd0));
      send_req(make_req(tcw_pkg::REQ_MOVE,  8'h00, 4'h0, 4'h0, 7'(COLS - 1),
                        5'(ROWS - 1)));
      // wrap off the last cell of the last row scrolls
      send_req(make_req(tcw_pkg::REQ_PUT,   8'h78, 4'hA, 4'h5, 7'd0,   5'd0));
      send_req(make_req(tcw_pkg::REQ_READ,  8'h00, 4'h0, 4'h0, 7'(COLS - 1),
                        5'(ROWS - 2)));
      send_req(make_req(tcw_pkg::REQ_READ,  8'h00, 4'h0, 4'h0, 7'd0,   5'(ROWS - 1)));
      send_req(make_req(tcw_pkg::REQ_PUT,   tcw_pkg::NEWLINE_CHAR, 4'h0, 4'h0, 7'd0,
                        5'd0));
      send_req(make_req(tcw_pkg::REQ_READ,  8'h00, 4'h0, 4'h0, 7'd127, 5'd31));
      send_req(make_req(tcw_pkg::REQ_READ,  8'h00, 4'h0, 4'h0, 7'(COLS), 5'(ROWS - 1)));
      send_req(make_req(tcw_pkg::REQ_CLEAR, 8'hFF, 4'hF, 4'hF, 7'd127, 5'd31));
      send_req(make_req(tcw_pkg::REQ_READ,  8'h00, 4'h0, 4'h0, 7'(COLS - 1),
                        5'(ROWS - 1)));
      send_req(make_req(tcw_pkg::REQ_MOVE,  8'h00, 4'h0, 4'h0, 7'd0,   5'd0));
      send_req(make_req(tcw_pkg::REQ_PUT,   tcw_pkg::NEWLINE_CHAR, 4'hF, 4'hF, 7'd0,
                        5'd0));
      send_req(make_req(tcw_pkg::REQ_READ,  8'h00, 4'h0, 4'h0, 7'd0,   5'd0));
   endtask

   initial begin
      logic [3:0] fill_table [PHASES][2];
      sb = new();
      fill_table = '{'{4'hF, 4'hF}, '{4'h0, 4'h0}, '{4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15))}, '{4'hF, 4'h0},
                     '{4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))}};

      // reset is held at the start, then the block clears its store on its own
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed_requests();

      for (int p = 0; p < PHASES; p++) begin
         drain();
         set_fill(fill_table[p][0], fill_table[p][1]);
         // phase two runs back to back with no idling anywhere
         calm = (p == 2);
         for (int n = 0; n < ITEMS_A_PHASE; n++) begin
            if (p == 3 && n == 40) hold_off = 1'b1;
            send_req(random_request());
         end
      end
      calm = 1'b0;

      // all requests are in; let the owed responses come home, then look for strays
      drain();
      repeat (NCELLS + 10) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
